### src/dcp_pkg.sv
`default_nettype none

package dcp_pkg;

  localparam int unsigned MaxStoredDefault = 2;

  localparam logic [7:0]  SeparatorReset = 8'd44;
  localparam logic [15:0] LimitReset     = 16'hFFFF;

  localparam logic [7:0] CmdS = "S";
  localparam logic [7:0] CmdI = "I";
  localparam logic [7:0] CmdD = "D";
  localparam logic [7:0] CmdR = "R";
  localparam logic [7:0] CmdZ = "Z";
  localparam logic [7:0] CmdC = "C";

  localparam logic [0:0] CfgSeparator = 1'b0;
  localparam logic [0:0] CfgLimit     = 1'b1;

  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusParse    = 3'd1,
    StatusUnknown  = 3'd2,
    StatusMismatch = 3'd3,
    StatusArgCount = 3'd4
  } status_e;

  typedef struct packed {
    logic       found;
    logic [1:0] nargs;
  } cmd_info_t;

  function automatic cmd_info_t cmd_lookup(input logic [7:0] code);
    cmd_info_t info;
    info = '{found: 1'b1, nargs: 2'd0};
    unique case (code)
      CmdS, CmdI, CmdZ: info.nargs = 2'd0;
      CmdD, CmdR:       info.nargs = 2'd2;
      CmdC:             info.nargs = 2'd1;
      default:          info.found = 1'b0;
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

### src/delimited_command_parser.sv
// Command line parser for a character stream.
// Slave side: one beat per character; tuser = 1 marks the end beat that closes the
// command, tdata carries the character (ignored on the end beat).
// Master side: one beat per end beat with status, command code, argument count and
// the first two stored argument values. Character beats give no output.
// Config channel: cfg_addr_i 0 sets the separator (cfg_data_i[7:0]), 1 sets the
// saturation limit for decimal values; always ready, write only while idle.
// Throughput: one beat per cycle while no end beat waits. Each beat goes through an
// input register and is folded into the parse state from there; the result of an end
// beat is registered in the output register as the beat leaves the input register.
// When the receiver stalls, the output register holds its beat; character beats
// keep flowing, and an end beat waits in the input register until the output
// register frees, with the slave side stalled while it waits.
// Reset clears the parse state, empties both registers and restores the separator
// to a comma and the limit to 65535.
`default_nettype none

module delimited_command_parser #(
  parameter int unsigned MAX_STORED = dcp_pkg::MaxStoredDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // char_code
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // status, command_code, arg_count,
                                           // first_arg, second_arg, zero fill
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_data_i
);
  import dcp_pkg::*;

  localparam int unsigned StoreSlots = (MAX_STORED < 2) ? 2 : MAX_STORED;

  logic [7:0]  sep_q;
  logic [15:0] limit_q;

  logic        in_valid_q;
  logic        in_kind_q;
  logic [7:0]  in_char_q;
  logic        adv;

  logic [1:0]  pos_q, pos_d;
  logic [1:0]  cc_q, cc_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [19:0] acc_q, acc_d;
  logic        bad_q, bad_d;
  logic [15:0] decl_q, decl_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] store_q [StoreSlots];
  logic [15:0] store_d [StoreSlots];
  logic        pe_q, pe_d;

  logic        cl_pe;
  logic [1:0]  cl_pos;
  logic [15:0] cl_decl;
  logic [7:0]  cl_cnt;
  logic [15:0] cl_store [StoreSlots];
  logic [15:0] sat_val;

  logic        out_valid_q;
  logic [47:0] out_data_q, out_data_d;

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign adv           = in_valid_q && (!in_kind_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  // field close
  always_comb begin
    cl_pe    = pe_q;
    cl_pos   = pos_q;
    cl_decl  = decl_q;
    cl_cnt   = cnt_q;
    cl_store = store_q;
    sat_val  = (acc_q > {4'b0, limit_q}) ? limit_q : acc_q[15:0];
    if (pos_q == 2'd0) begin
      if (cc_q != 2'd1) cl_pe = 1'b1;
    end else if (cc_q == 2'd0 || bad_q) begin
      cl_pe = 1'b1;
    end else if (pos_q == 2'd1) begin
      cl_decl = sat_val;
    end else begin
      for (int i = 0; i < StoreSlots; i++) begin
        if (i < MAX_STORED && cnt_q == 8'(i)) cl_store[i] = sat_val;
      end
      if (cnt_q != 8'hFF) cl_cnt = cnt_q + 8'd1;
    end
    if (!cl_pe && pos_q != 2'd2) cl_pos = pos_q + 2'd1;
  end

  // next parse state and result
  always_comb begin
    cmd_info_t  info;
    status_e    status;
    logic [7:0] code;
    logic [1:0] nargs;
    logic [15:0] second;
    pos_d   = pos_q;
    cc_d    = cc_q;
    cmd_d   = cmd_q;
    acc_d   = acc_q;
    bad_d   = bad_q;
    decl_d  = decl_q;
    cnt_d   = cnt_q;
    store_d = store_q;
    pe_d    = pe_q;
    info    = cmd_lookup(cmd_q);
    status  = StatusOk;
    nargs   = 2'd0;
    code    = (cl_pos != 2'd0) ? cmd_q : 8'd0;
    second  = (MAX_STORED > 1) ? cl_store[1] : 16'd0;

    if (pe_q || cl_pe || cl_pos != 2'd2) begin
      status = StatusParse;
    end else if (!info.found) begin
      status = StatusUnknown;
    end else if (cl_decl != {8'd0, cl_cnt}) begin
      status = StatusMismatch;
    end else if (cl_cnt != {6'd0, info.nargs}) begin
      status = StatusArgCount;
    end else begin
      nargs = cl_cnt[1:0];
    end
    out_data_d = {3'd0, second, cl_store[0], nargs, code, status};

    if (!in_kind_q) begin
      if (!pe_q) begin
        if (in_char_q == sep_q) begin
          pe_d    = cl_pe;
          pos_d   = cl_pos;
          decl_d  = cl_decl;
          cnt_d   = cl_cnt;
          store_d = cl_store;
          cc_d    = 2'd0;
          acc_d   = 20'd0;
          bad_d   = 1'b0;
        end else begin
          if (pos_q == 2'd0) begin
            if (cc_q == 2'd0) cmd_d = in_char_q;
          end else if (in_char_q < "0" || in_char_q > "9") begin
            bad_d = 1'b1;
          end else if (acc_q <= {4'b0, limit_q}) begin
            acc_d = acc_q * 20'd10 + {16'd0, in_char_q[3:0]};
          end
          if (cc_q != 2'd3) cc_d = cc_q + 2'd1;
        end
      end
    end else begin
      pos_d  = 2'd0;
      cc_d   = 2'd0;
      cmd_d  = 8'd0;
      acc_d  = 20'd0;
      bad_d  = 1'b0;
      decl_d = 16'd0;
      cnt_d  = 8'd0;
      pe_d   = 1'b0;
      for (int i = 0; i < StoreSlots; i++) store_d[i] = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q       <= SeparatorReset;
      limit_q     <= LimitReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= 2'd0;
      cc_q        <= 2'd0;
      cmd_q       <= 8'd0;
      acc_q       <= 20'd0;
      bad_q       <= 1'b0;
      decl_q      <= 16'd0;
      cnt_q       <= 8'd0;
      pe_q        <= 1'b0;
      for (int i = 0; i < StoreSlots; i++) store_q[i] <= 16'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          CfgSeparator: sep_q   <= cfg_data_i[7:0];
          CfgLimit:     limit_q <= cfg_data_i;
          default:      ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        pos_q   <= pos_d;
        cc_q    <= cc_d;
        cmd_q   <= cmd_d;
        acc_q   <= acc_d;
        bad_q   <= bad_d;
        decl_q  <= decl_d;
        cnt_q   <= cnt_d;
        pe_q    <= pe_d;
        store_q <= store_d;
      end
      if (adv && in_kind_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser;
      in_char_q <= s_axis_tdata;
    end
    if (adv && in_kind_q) begin
      out_data_q <= out_data_d;
    end
  end

  a_out_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q && in_kind_q))
    else $error("output beat without an end beat");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd3)
    else $error("field position out of range");

  a_fail_no_args: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[2:0] != StatusOk) |-> out_data_q[12:11] == 2'd0)
    else $error("argument count on a failed command");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_kind_q) |=> (pos_q == 2'd0 && cnt_q == 8'd0 && !pe_q))
    else $error("parse state not cleared after end beat");

endmodule

`default_nettype wire
